>>> hw/rtl/point_set_min_distance_assert.svh
// Assertion macros shared by the RTL files; clk and rst_n must be in scope.
`ifndef POINT_SET_MIN_DISTANCE_ASSERT_SVH
`define POINT_SET_MIN_DISTANCE_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define PMD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define PMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pmd_pkg.sv
package pmd_pkg;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd2;

    localparam int IN_COORD_W  = 24;
    localparam int OUT_SQ_W    = 52;
    localparam int OUT_DIST_W  = 26;
    localparam int OUT_DELTA_W = 25;

    localparam int S_TDATA_W = 3 * IN_COORD_W;
    localparam int M_TDATA_W = 160;
    localparam int OUT_PAD_W = M_TDATA_W - (OUT_SQ_W + OUT_DIST_W + 3 * OUT_DELTA_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ROOT,
        ST_EMIT
    } pmd_state_t;

    typedef struct packed {
        logic store_clear;
        logic store_append;
        logic query_load;
        logic scan_issue;
        logic root_start;
        logic out_load;
    } pmd_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic pipe_empty;
        logic root_busy;
        logic out_free;
    } pmd_stat_t;

endpackage

>>> hw/rtl/pmd_ram.sv
module pmd_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/pmd_isqrt.sv
module pmd_isqrt #(
    parameter int W = 52
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [W-1:0]      din,
    output logic              busy,
    output logic [W/2-1:0]    root
);

    localparam int RW = W / 2;
    localparam int CW = $clog2(RW + 1);

    logic [W-1:0]  val_reg,  val_next;
    logic [RW+1:0] rem_reg,  rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;

    // One result bit per cycle, restoring digit recurrence.
    always_comb
    begin
        rem_sh    = {rem_reg[RW-1:0], val_reg[W-1:W-2]};
        trial     = {root_reg, 2'b01};
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            val_next  = din;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

>>> hw/rtl/pmd_datapath.sv
`include "point_set_min_distance_assert.svh"

module pmd_datapath
    import pmd_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int COORD_BITS  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pmd_cmd_t                      cmd,
    output pmd_stat_t                     stat,
    input  logic [IN_COORD_W-1:0]         in_x,
    input  logic [IN_COORD_W-1:0]         in_y,
    input  logic [IN_COORD_W-1:0]         in_z,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [STATUS_W-1:0]           out_status,
    output logic [OUT_SQ_W-1:0]           out_sq,
    output logic [OUT_DIST_W-1:0]         out_dist,
    output logic [OUT_DELTA_W-1:0]        out_dx,
    output logic [OUT_DELTA_W-1:0]        out_dy,
    output logic [OUT_DELTA_W-1:0]        out_dz
);

    localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
    localparam int DELTA_W = COORD_BITS + 1;
    localparam int SQR_W   = 2 * DELTA_W;
    localparam int SUM_W   = SQR_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int ENTRY_W = 3 * COORD_BITS;

    // Take the low COORD_BITS of the field, zero-filled above the field width.
    function automatic logic [COORD_BITS-1:0] take_coord(input logic [IN_COORD_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[COORD_BITS-1:0];
    endfunction

    function automatic logic [OUT_DELTA_W-1:0] fit_delta(input logic signed [DELTA_W-1:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[OUT_DELTA_W-1:0];
    endfunction

    logic [CNT_W-1:0]            count_reg, issue_reg;
    logic                        ovf_reg;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;

    logic                        ram_we;
    logic [ENTRY_W-1:0]          ram_wdata, ram_rdata;
    logic signed [COORD_BITS-1:0] sx, sy, sz;

    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DELTA_W-1:0]   dx_reg, dy_reg, dz_reg;
    logic signed [DELTA_W-1:0]   ex_reg, ey_reg, ez_reg;
    logic signed [DELTA_W-1:0]   fx_reg, fy_reg, fz_reg;
    logic [SQR_W-1:0]            sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0]            sum_reg;

    logic [SUM_W-1:0]            best_sq_reg;
    logic                        have_best_reg;
    logic signed [DELTA_W-1:0]   bdx_reg, bdy_reg, bdz_reg;
    logic                        take_new;

    logic                        root_busy;
    logic [ROOT_W-1:0]           root;
    logic [63:0]                 root_wide, sq_wide;

    logic                        out_valid_reg;
    logic [STATUS_W-1:0]         status_next;

    assign ram_we    = cmd.store_append && (count_reg < CNT_W'(STORE_DEPTH));
    assign ram_wdata = {take_coord(in_z), take_coord(in_y), take_coord(in_x)};

    pmd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(ram_wdata),
        .raddr(issue_reg[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            issue_reg <= '0;
        end
        else
        begin
            if (cmd.store_clear)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.store_append)
            begin
                if (ram_we)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.query_load)
            begin
                issue_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_load)
        begin
            qx_reg <= take_coord(in_x);
            qy_reg <= take_coord(in_y);
            qz_reg <= take_coord(in_z);
        end
    end

    // Scan pipe: read, difference, square, sum, compare.
    assign sx = ram_rdata[COORD_BITS-1:0];
    assign sy = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign sz = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= DELTA_W'(sx) - DELTA_W'(qx_reg);
        dy_reg  <= DELTA_W'(sy) - DELTA_W'(qy_reg);
        dz_reg  <= DELTA_W'(sz) - DELTA_W'(qz_reg);
        sqx_reg <= SQR_W'(dx_reg * dx_reg);
        sqy_reg <= SQR_W'(dy_reg * dy_reg);
        sqz_reg <= SQR_W'(dz_reg * dz_reg);
        ex_reg  <= dx_reg;
        ey_reg  <= dy_reg;
        ez_reg  <= dz_reg;
        sum_reg <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
        fx_reg  <= ex_reg;
        fy_reg  <= ey_reg;
        fz_reg  <= ez_reg;
    end

    // Strict compare keeps the first minimum.
    assign take_new = v4_reg && (!have_best_reg || (sum_reg < best_sq_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sq_reg   <= '0;
            have_best_reg <= 1'b0;
            bdx_reg       <= '0;
            bdy_reg       <= '0;
            bdz_reg       <= '0;
        end
        else if (cmd.store_clear || cmd.out_load)
        begin
            best_sq_reg   <= '0;
            have_best_reg <= 1'b0;
            bdx_reg       <= '0;
            bdy_reg       <= '0;
            bdz_reg       <= '0;
        end
        else if (take_new)
        begin
            best_sq_reg   <= sum_reg;
            have_best_reg <= 1'b1;
            bdx_reg       <= fx_reg;
            bdy_reg       <= fy_reg;
            bdz_reg       <= fz_reg;
        end
    end

    pmd_isqrt #(
        .W(SUM_W)
    ) u_isqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.root_start),
        .din  (best_sq_reg),
        .busy (root_busy),
        .root (root)
    );

    assign root_wide = 64'(root);
    assign sq_wide   = 64'(best_sq_reg);

    always_comb
    begin
        priority if (count_reg == '0)
        begin
            status_next = STAT_EMPTY;
        end
        else if (ovf_reg)
        begin
            status_next = STAT_DROPPED;
        end
        else
        begin
            status_next = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status <= status_next;
            out_sq     <= sq_wide[OUT_SQ_W-1:0];
            out_dist   <= root_wide[OUT_DIST_W-1:0];
            out_dx     <= fit_delta(bdx_reg);
            out_dy     <= fit_delta(bdy_reg);
            out_dz     <= fit_delta(bdz_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign stat.scan_end   = (issue_reg >= count_reg);
    assign stat.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign stat.root_busy  = root_busy;
    assign stat.out_free   = !out_valid_reg || out_ready;

    `PMD_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(STORE_DEPTH),
        "stored point count beyond store depth")
    `PMD_ASSERT_NEXT(a_load_clears_best, cmd.out_load, out_valid_reg && !have_best_reg,
        "result load did not clear running minimum")
    `PMD_ASSERT_NEXT(a_root_runs, cmd.root_start, root_busy,
        "square root unit did not start")

endmodule

>>> hw/rtl/pmd_ctrl.sv
`include "point_set_min_distance_assert.svh"

module pmd_ctrl
    import pmd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] in_command,
    input  logic             in_last,
    output logic             in_ready,
    output pmd_cmd_t         cmd,
    input  pmd_stat_t        stat
);

    pmd_state_t state_reg, state_next;
    logic       last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_command)
                        CMD_CLEAR:  cmd.store_clear  = 1'b1;
                        CMD_APPEND: cmd.store_append = 1'b1;
                        CMD_QUERY:
                        begin
                            cmd.query_load = 1'b1;
                            last_next      = in_last;
                            state_next     = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last compare to land
                if (stat.pipe_empty)
                begin
                    if (last_reg)
                    begin
                        cmd.root_start = 1'b1;
                        state_next     = ST_ROOT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ROOT:
            begin
                if (!stat.root_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // hold until the output register can take the item
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `PMD_ASSERT_SAME(a_root_only_last, state_reg == ST_ROOT, last_reg,
        "square root run on a query that is not last")

endmodule

>>> hw/rtl/point_set_min_distance.sv
// Closest pair between a stored point set and streamed query points.
// Input channel s_*: s_tuser carries the command (clear, append, query), s_tdata
// the x, y, z coordinates, s_tlast marks the last query of a batch.
// Clear and append complete without leaving the idle state; an append to a full store is dropped.
// A query scans one stored point per cycle through a single store read port:
// s_tready stays low until its scan has drained through the compare stage.
// The last query adds a bit-serial square root and then a load of the result
// into the output register, after which one item appears on m_*.
// m_tuser carries the status, m_tdata the squared distance, its floor root and
// the stored-minus-query vector. The result waits in an output register; input
// items are still taken while it waits, and a second result holds the scan
// engine until the first one is taken.
// Reset empties the store, clears the running minimum and the output valid.
// Stored points are never read beyond the fill count, so no clearing pass runs.
module point_set_min_distance
    import pmd_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int COORD_BITS  = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // coord_x, coord_y, coord_z
    input  logic [CMD_W-1:0]     s_tuser,   // command
    input  logic                 s_tlast,   // last_query
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // min_dist_sq, min_dist, delta_x/y/z, pad
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    pmd_cmd_t                cmd;
    pmd_stat_t               stat;
    logic [OUT_SQ_W-1:0]     out_sq;
    logic [OUT_DIST_W-1:0]   out_dist;
    logic [OUT_DELTA_W-1:0]  out_dx, out_dy, out_dz;

    pmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_command(s_tuser),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pmd_datapath #(
        .STORE_DEPTH(STORE_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_x      (s_tdata[IN_COORD_W-1:0]),
        .in_y      (s_tdata[2*IN_COORD_W-1:IN_COORD_W]),
        .in_z      (s_tdata[3*IN_COORD_W-1:2*IN_COORD_W]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_status(m_tuser),
        .out_sq    (out_sq),
        .out_dist  (out_dist),
        .out_dx    (out_dx),
        .out_dy    (out_dy),
        .out_dz    (out_dz)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_dz, out_dy, out_dx, out_dist, out_sq};

endmodule
